// ===== hw/rtl/fbpa_pkg.sv =====
// Shared types and constants of the fixed buffer pool allocator.
package fbpa_pkg;

    localparam int ADDR_W      = 64;
    localparam int SIZE_W      = 22;
    localparam int COUNT_W     = 9;
    localparam int FREE_W      = 9;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LIMIT_W     = SIZE_W + COUNT_W;
    localparam int COUNT_MAX   = (2 ** COUNT_W) - 1;

    localparam logic [SIZE_W-1:0]  SIZE_LIMIT  = SIZE_W'(2097152);
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(4096);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

    localparam logic [CFG_INDEX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 2'd2;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_FRESH = 2'd1;
    localparam logic [1:0] KIND_POP   = 2'd2;
    localparam logic [1:0] KIND_PUSH  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] buffer_address;
    } fbpa_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted_address;
        logic [FREE_W-1:0]   free_count;
    } fbpa_out_t;

    typedef struct packed {
        logic                load_item;
        logic                calc_offset;
        logic                div_init;
        logic                div_step;
        logic                queue_read;
        logic                finish;
        logic [1:0]          kind;
        logic [STATUS_W-1:0] status;
    } fbpa_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            fresh_avail;
        logic            queue_nonempty;
        logic            in_range;
        logic            rem_zero;
        logic            list_full;
        logic            out_free;
    } fbpa_stat_t;

endpackage

// ===== hw/rtl/fbpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/fbpa_dp.sv =====
// Datapath: configuration, free list pointers, release check divider and output register.
module fbpa_dp import fbpa_pkg::*; #(
    parameter int MAX_BUFS    = 256,
    parameter int QUEUE_DEPTH = 512
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  fbpa_in_t               in_item,
    input  fbpa_cmd_t              cmd,
    output fbpa_stat_t             stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fbpa_out_t              out_item
);

    localparam int CNT_CAP = (MAX_BUFS < COUNT_MAX) ? MAX_BUFS : COUNT_MAX;
    localparam int QW      = (CNT_CAP > 1) ? $clog2(CNT_CAP) : 1;
    localparam int QAW     = $clog2(QUEUE_DEPTH);
    localparam int FW      = (QAW > COUNT_W + 1) ? QAW + 1 : COUNT_W + 2;
    localparam int DVS_W   = SIZE_W + QW - 1;

    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;

    logic [COUNT_W-1:0] fresh_reg, fresh_next;
    logic [ADDR_W-1:0]  fresh_addr_reg, fresh_addr_next;
    logic [QAW-1:0]     head_reg, head_next;
    logic [QAW-1:0]     tail_reg, tail_next;
    logic [QAW-1:0]     used_reg, used_next;

    fbpa_in_t           item_reg, item_next;
    logic [ADDR_W-1:0]  off_reg, off_next;
    logic [LIMIT_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;

    logic               out_valid_reg, out_valid_next;
    fbpa_out_t          out_item_reg, out_item_next;

    logic [SIZE_W-1:0]  eff_size;
    logic [COUNT_W-1:0] eff_cnt;
    logic [FW-1:0]      free_total;
    logic [FW-1:0]      free_after;
    logic [FW-1:0]      cap;
    logic [FW-1:0]      cap_pairs;
    logic [ADDR_W-1:0]  ram_rdata;
    logic               ram_wr_en;
    logic [QAW-1:0]     head_bump;
    logic [QAW-1:0]     tail_bump;
    logic               cfg_known;
    fbpa_out_t          result;

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (size_reg > SIZE_LIMIT)
        begin
            eff_size = SIZE_LIMIT;
        end
        else
        begin
            eff_size = size_reg;
        end

        if (count_reg == '0)
        begin
            eff_cnt = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(CNT_CAP))
        begin
            eff_cnt = COUNT_W'(CNT_CAP);
        end
        else
        begin
            eff_cnt = count_reg;
        end
    end

    assign limit_next = LIMIT_W'(eff_cnt) * LIMIT_W'(eff_size);
    assign free_total = FW'(eff_cnt - fresh_reg) + FW'(used_reg);
    assign cap_pairs  = FW'({eff_cnt, 1'b0}) - FW'(1);
    assign cap        = (cap_pairs < FW'(QUEUE_DEPTH - 1)) ? cap_pairs : FW'(QUEUE_DEPTH - 1);
    assign head_bump  = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QAW'(1);
    assign tail_bump  = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + QAW'(1);
    assign cfg_known  = (cfg_index == REG_BASE) || (cfg_index == REG_SIZE)
                        || (cfg_index == REG_COUNT);

    always_comb
    begin
        stat.op             = item_reg.op;
        stat.fresh_avail    = fresh_reg < eff_cnt;
        stat.queue_nonempty = used_reg != '0;
        stat.in_range       = (off_reg[ADDR_W-1:LIMIT_W] == '0)
                              && (off_reg[LIMIT_W-1:0] < limit_reg);
        stat.rem_zero       = rem_reg == '0;
        stat.list_full      = free_total >= cap;
        stat.out_free       = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        result.status = cmd.status;
        unique case (cmd.kind)
            KIND_FRESH:
            begin
                result.granted_address = fresh_addr_reg;
                free_after             = free_total - FW'(1);
            end
            KIND_POP:
            begin
                result.granted_address = ram_rdata;
                free_after             = free_total - FW'(1);
            end
            KIND_PUSH:
            begin
                result.granted_address = '0;
                free_after             = free_total + FW'(1);
            end
            KIND_PLAIN:
            begin
                result.granted_address = '0;
                free_after             = free_total;
            end
        endcase
        result.free_count = free_after[FREE_W-1:0];
    end

    always_comb
    begin
        base_next       = base_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        fresh_addr_next = fresh_addr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        used_next       = used_reg;
        item_next       = item_reg;
        off_next        = off_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (cmd.load_item)
        begin
            item_next = in_item;
        end
        if (cmd.calc_offset)
        begin
            off_next = item_reg.buffer_address - base_reg;
        end
        if (cmd.div_init)
        begin
            rem_next = off_reg[LIMIT_W-1:0];
            dvs_next = DVS_W'(eff_size) << (QW - 1);
        end
        else if (cmd.div_step)
        begin
            if (LIMIT_W'(dvs_reg) <= rem_reg)
            begin
                rem_next = rem_reg - LIMIT_W'(dvs_reg);
            end
            dvs_next = dvs_reg >> 1;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_item_next  = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write && cfg_known)
        begin
            fresh_next      = '0;
            head_next       = '0;
            tail_next       = '0;
            used_next       = '0;
            fresh_addr_next = base_reg;
            unique case (cfg_index)
                REG_BASE:
                begin
                    base_next       = cfg_data;
                    fresh_addr_next = cfg_data;
                end
                REG_SIZE:  size_next  = cfg_data[SIZE_W-1:0];
                REG_COUNT: count_next = cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
        else if (cmd.finish)
        begin
            unique case (cmd.kind)
                KIND_FRESH:
                begin
                    fresh_next      = fresh_reg + COUNT_W'(1);
                    fresh_addr_next = fresh_addr_reg + ADDR_W'(eff_size);
                end
                KIND_POP:
                begin
                    head_next = head_bump;
                    used_next = used_reg - QAW'(1);
                end
                KIND_PUSH:
                begin
                    tail_next = tail_bump;
                    used_next = used_reg + QAW'(1);
                end
                KIND_PLAIN: ;
            endcase
        end
    end

    assign ram_wr_en = cmd.finish && (cmd.kind == KIND_PUSH);

    fbpa_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (item_reg.buffer_address),
        .rd_en   (cmd.queue_read),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            size_reg       <= SIZE_RESET;
            count_reg      <= COUNT_RESET;
            fresh_reg      <= '0;
            fresh_addr_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            base_reg       <= base_next;
            size_reg       <= size_next;
            count_reg      <= count_next;
            fresh_reg      <= fresh_next;
            fresh_addr_reg <= fresh_addr_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg    <= limit_next;
        item_reg     <= item_next;
        off_reg      <= off_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== hw/rtl/fbpa_ctrl.sv =====
// Controller: sequences acquire, release and query items through the datapath.
module fbpa_ctrl import fbpa_pkg::*; #(
    parameter int MAX_BUFS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  fbpa_stat_t stat,
    output fbpa_cmd_t  cmd
);

    localparam int CNT_CAP = (MAX_BUFS < COUNT_MAX) ? MAX_BUFS : COUNT_MAX;
    localparam int QW      = (CNT_CAP > 1) ? $clog2(CNT_CAP) : 1;
    localparam int SW      = (QW > 1) ? $clog2(QW) : 1;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_ACQ_WAIT = 3'd2;
    localparam logic [2:0] S_RANGE    = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_REL_END  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.op == OP_ACQUIRE)
                begin
                    priority if (stat.fresh_avail)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.finish = 1'b1;
                            cmd.kind   = KIND_FRESH;
                            cmd.status = ST_OK;
                            state_next = S_IDLE;
                        end
                    end
                    else if (stat.queue_nonempty)
                    begin
                        cmd.queue_read = 1'b1;
                        state_next     = S_ACQ_WAIT;
                    end
                    else
                    begin
                        if (stat.out_free)
                        begin
                            cmd.finish = 1'b1;
                            cmd.kind   = KIND_PLAIN;
                            cmd.status = ST_EXHAUSTED;
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (stat.op == OP_RELEASE)
                begin
                    cmd.calc_offset = 1'b1;
                    state_next      = S_RANGE;
                end
                else
                begin
                    if (stat.out_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = KIND_PLAIN;
                        cmd.status = ST_OK;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ACQ_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = KIND_POP;
                    cmd.status = ST_OK;
                    state_next = S_IDLE;
                end
            end
            S_RANGE:
            begin
                if (!stat.in_range)
                begin
                    if (stat.out_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = KIND_PLAIN;
                        cmd.status = ST_INVALID;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    step_next    = SW'(QW - 1);
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_REL_END;
                end
                else
                begin
                    step_next = step_reg - SW'(1);
                end
            end
            S_REL_END:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                    priority if (!stat.rem_zero)
                    begin
                        cmd.kind   = KIND_PLAIN;
                        cmd.status = ST_INVALID;
                    end
                    else if (stat.list_full)
                    begin
                        cmd.kind   = KIND_PLAIN;
                        cmd.status = ST_FULL;
                    end
                    else
                    begin
                        cmd.kind   = KIND_PUSH;
                        cmd.status = ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hw/rtl/fixed_buffer_pool_allocator.sv =====
// Top level of the fixed buffer pool allocator.
// Usage: items enter on in_valid/in_ready carrying op and buffer_address; one
// result per item leaves on out_valid/out_ready with status, granted_address
// and free_count. Registers are written through cfg_write/cfg_index/cfg_data
// while no item is in flight; any write to base, size or count empties the
// free list and restarts fresh buffers at the base address.
// A query, a fresh acquire or an exhausted acquire finishes in the decode step;
// an acquire served from the release queue first does one RAM read; a release
// checks the range, then runs the restoring divider that takes one quotient
// bit per cycle to check buffer alignment. One item is worked on at a time;
// the next is accepted the cycle after the previous result is loaded into the
// output register.
// If the receiver stalls, the result waits in the output register and one
// more item may be accepted and worked up to its final step, where it holds.
// Reset restores base 0, size 4096, count 256 and a full pool of fresh
// buffers; the release queue needs no clearing.
module fixed_buffer_pool_allocator import fbpa_pkg::*; #(
    parameter int MAX_BUFS    = 256,
    parameter int QUEUE_DEPTH = 512
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fbpa_in_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fbpa_out_t              out_item
);

    fbpa_cmd_t  cmd;
    fbpa_stat_t stat;

    fbpa_ctrl #(
        .MAX_BUFS (MAX_BUFS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbpa_dp #(
        .MAX_BUFS    (MAX_BUFS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
